### rtl/core/tamm_pkg.sv
// Package for the telemetry averager with minimum and maximum tracking.
// Holds the item command codes and the sample width; no dependencies.
`default_nettype none

package tamm_pkg;

    localparam int SAMPLE_W = 8;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef enum logic
    {
        FUNC_SAMPLE = 1'b0,
        FUNC_CLEAR  = 1'b1
    } func_t;

endpackage

`default_nettype wire

### rtl/core/tamm_in_if.sv
// Input channel of the telemetry averager: valid/ready handshake and one sample item.
// Depends on tamm_pkg for the command code and sample types.
`default_nettype none

interface tamm_in_if
    import tamm_pkg::*;
();

    logic    valid;
    logic    ready;
    func_t   func;
    sample_t sample;
    logic    is_volts;

    modport source
    (
        output valid,
        input  ready,
        output func,
        output sample,
        output is_volts
    );

    modport sink
    (
        input  valid,
        output ready,
        input  func,
        input  sample,
        input  is_volts
    );

endinterface

`default_nettype wire

### rtl/core/tamm_out_if.sv
// Result channel of the telemetry averager: valid/ready handshake and one result item.
// Depends on tamm_pkg for the sample type.
`default_nettype none

interface tamm_out_if
    import tamm_pkg::*;
();

    logic    valid;
    logic    ready;
    sample_t shown_value;
    sample_t minimum;
    sample_t maximum;

    modport source
    (
        output valid,
        input  ready,
        output shown_value,
        output minimum,
        output maximum
    );

    modport sink
    (
        input  valid,
        output ready,
        input  shown_value,
        input  minimum,
        input  maximum
    );

endinterface

`default_nettype wire

### rtl/core/telemetry_average_min_max.sv
// Telemetry averager with minimum and maximum tracking.
// Each item on telem carries either a new sample or a clear command; for every item
// exactly one result item leaves on report with the shown value, minimum and maximum.
// For volts the shown value is the window sum plus the new sample divided by
// WINDOW_LEN + 1, save that the first reading is shown raw; otherwise it is the raw
// sample. A shown value of zero means no reading yet, and the first reading fills the whole window.
// An accepted item is held in the input register, and its result is registered in the
// result register and presented there with valid.
// Throughput is one item per clock cycle while report does not stall; the window sum, the
// reciprocal multiply and the state update all fit between the input and result registers.
// When report stalls, the result register holds its item and the input register can
// still take one more item, after which telem.ready falls until report drains.
// Reset clears the window, the shown value, both marks and all valid flags; a clear
// command returns the window, the shown value and both marks to zero at run time.
`default_nettype none

module telemetry_average_min_max
    import tamm_pkg::*;
#(
    parameter int WINDOW_LEN = 3
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    tamm_in_if.sink          telem,
    tamm_out_if.source       report
);

    localparam int DIV       = WINDOW_LEN + 1;
    localparam int SUM_W     = $clog2(DIV * 255 + 1);
    localparam int RSHIFT    = SUM_W + $clog2(DIV) + 1;
    localparam int RECIP     = ((2 ** RSHIFT) + DIV - 1) / DIV;
    localparam int PROD_W    = SUM_W + RSHIFT;

    logic    s1_valid_reg;
    func_t   s1_func_reg;
    sample_t s1_sample_reg;
    logic    s1_volts_reg;

    sample_t history_reg [WINDOW_LEN];
    sample_t history_next [WINDOW_LEN];
    sample_t current_reg;
    sample_t current_next;
    sample_t low_mark_reg;
    sample_t low_mark_next;
    sample_t high_mark_reg;
    sample_t high_mark_next;

    logic    out_valid_reg;
    sample_t out_shown_reg;
    sample_t out_min_reg;
    sample_t out_max_reg;

    logic              advance;
    logic              fire;
    logic              first_reading;
    logic [SUM_W-1:0]  window_sum;
    logic [PROD_W-1:0] product;
    sample_t           average;

    assign advance     = !out_valid_reg || report.ready;
    assign fire        = s1_valid_reg && advance;
    assign telem.ready = !s1_valid_reg || advance;

    assign report.valid       = out_valid_reg;
    assign report.shown_value = out_shown_reg;
    assign report.minimum     = out_min_reg;
    assign report.maximum     = out_max_reg;

    always_comb
    begin
        window_sum = SUM_W'(s1_sample_reg);
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            window_sum = window_sum + SUM_W'(history_reg[i]);
        end
    end

    assign product = PROD_W'(window_sum) * PROD_W'(RECIP);
    assign average = product[RSHIFT +: SAMPLE_W];

    assign first_reading = (current_reg == '0);

    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            history_next[i] = history_reg[i];
        end
        current_next   = current_reg;
        low_mark_next  = low_mark_reg;
        high_mark_next = high_mark_reg;

        if (s1_func_reg == FUNC_CLEAR)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                history_next[i] = '0;
            end
            current_next   = '0;
            low_mark_next  = '0;
            high_mark_next = '0;
        end
        else
        begin
            if (first_reading)
            begin
                for (int i = 0; i < WINDOW_LEN; i++)
                begin
                    history_next[i] = s1_sample_reg;
                end
                current_next = s1_sample_reg;
            end
            else
            begin
                for (int i = 0; i < WINDOW_LEN - 1; i++)
                begin
                    history_next[i] = history_reg[i + 1];
                end
                history_next[WINDOW_LEN - 1] = s1_sample_reg;
                current_next = average;
            end

            if (!s1_volts_reg)
            begin
                current_next = s1_sample_reg;
            end

            if (low_mark_reg == '0 || s1_sample_reg < low_mark_reg)
            begin
                low_mark_next = s1_sample_reg;
            end

            if (high_mark_reg == '0 || s1_sample_reg > high_mark_reg)
            begin
                high_mark_next = s1_sample_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (telem.ready)
            begin
                s1_valid_reg <= telem.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                history_reg[i] <= '0;
            end
            current_reg   <= '0;
            low_mark_reg  <= '0;
            high_mark_reg <= '0;
        end
        else if (fire)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                history_reg[i] <= history_next[i];
            end
            current_reg   <= current_next;
            low_mark_reg  <= low_mark_next;
            high_mark_reg <= high_mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (telem.valid && telem.ready)
        begin
            s1_func_reg   <= telem.func;
            s1_sample_reg <= telem.sample;
            s1_volts_reg  <= telem.is_volts;
        end
        if (fire)
        begin
            out_shown_reg <= current_next;
            out_min_reg   <= low_mark_next;
            out_max_reg   <= high_mark_next;
        end
    end

    // A clear item leaves every tracked value at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_func_reg == FUNC_CLEAR
        |=> current_reg == '0 && low_mark_reg == '0 && high_mark_reg == '0)
        else $error("clear item did not zero the tracked values");

    // Once set, the minimum never exceeds the maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        low_mark_reg != '0 |-> low_mark_reg <= high_mark_reg)
        else $error("minimum above maximum");

    // A sample in a unit other than volts is shown raw.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_func_reg == FUNC_SAMPLE && !s1_volts_reg
        |=> current_reg == $past(s1_sample_reg))
        else $error("raw sample not shown for non-volt unit");

    // A result appears only after an item left the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result item without a source item");

    // The result register reports the state that the item left behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_shown_reg == current_reg && out_min_reg == low_mark_reg
            && out_max_reg == high_mark_reg)
        else $error("result item differs from tracked state");

endmodule

`default_nettype wire
